// ===== rtl/shared_bandwidth_token_limiter_macros.svh =====
// Assertion macros shared by the token limiter RTL.
`ifndef SHARED_BANDWIDTH_TOKEN_LIMITER_MACROS_SVH
`define SHARED_BANDWIDTH_TOKEN_LIMITER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication on clk, disabled in reset.
`define SBTL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token limiter assertion failed");
// Next-cycle implication on clk, disabled in reset.
`define SBTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token limiter assertion failed");
`else
`define SBTL_ASSERT_IMPL(lbl, ante, cons)
`define SBTL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/sbtl_pkg.sv =====
// Types and constants for the token limiter.
`default_nettype none
package sbtl_pkg;

  // Default grant cap in bytes
  localparam int unsigned MAX_GRANT_DEF = 100 * 1024;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_GRANT  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e_t;

  // Register indexes on the configuration port
  localparam logic REG_RATE_LIMIT   = 1'b0;
  localparam logic REG_WORKER_COUNT = 1'b1;

  // Reset value of the worker count
  localparam logic [6:0] WORKER_COUNT_RST = 7'd3;

  // Divider control from the sequencer
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// ===== rtl/sbtl_div.sv =====
// Radix-2 restoring divider: 32-bit budget by 7-bit worker count.
`default_nettype none
module sbtl_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sbtl_pkg::div_ctl_t ctl,
  input  wire logic [31:0]      dividend,
  input  wire logic [6:0]       divisor,
  output sbtl_pkg::div_sts_t    sts,
  output logic [31:0]           quotient
);
  import sbtl_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [6:0]  dvsr_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [7:0]  trial;
  logic        fits;

  // One quotient bit per cycle: shift in, compare, subtract
  always_comb begin
    trial   = {rem_r, quo_r[31]};
    fits    = trial >= {1'b0, dvsr_r};
    rem_nxt = fits ? 7'(trial - {1'b0, dvsr_r}) : trial[6:0];
    quo_nxt = {quo_r[30:0], fits};
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; a zero divisor divides as one
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= (divisor == 7'd0) ? 7'd1 : divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/shared_bandwidth_token_limiter.sv =====
// Top level of the shared bandwidth token limiter.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, in_command, in_remaining_bytes, in_received_bytes
//  out     | output    | out_valid, out_ready, out_grant_bytes, out_must_wait, out_last_rate
//  cfg     | APB slave | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Tick, report and grants settled by compare reach the output register in the cycle after accept.
// A grant that shares the leftover budget runs the bit-serial divider for 32 steps;
// the result is registered when the divider reports done, and the state then returns to idle.
// in_ready is low while the divider runs.
// A waiting result does not block a new item if out_ready is high in that cycle.
// Synchronous active-low reset; budget, counters and limit clear, workers reset to 3.
`default_nettype none
`include "shared_bandwidth_token_limiter_macros.svh"
module shared_bandwidth_token_limiter #(
  parameter int unsigned MAX_GRANT = sbtl_pkg::MAX_GRANT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_remaining_bytes,
  input  wire logic [16:0] in_received_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      out_grant_bytes,
  output logic             out_must_wait,
  output logic [31:0]      out_last_rate,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sbtl_pkg::*;

  localparam logic [31:0] MaxGrantW = 32'(MAX_GRANT);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] rate_limit_r;
  logic [6:0]  worker_count_r;
  logic [31:0] budget_r, budget_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [16:0] grant_r, grant_nxt;
  logic        wait_r, wait_nxt;
  logic [31:0] lrate_r, lrate_nxt;
  logic        in_acc, cfg_wr;
  logic [31:0] want;
  logic        want_ok;
  div_ctl_t    div_ctl;
  div_sts_t    div_sts;
  logic [31:0] quotient;

  // Cap a grant and mask it to the port width
  function automatic logic [16:0] cap_grant(input logic [31:0] w);
    logic [31:0] c;
    c = (w > MaxGrantW) ? MaxGrantW : w;
    return c[16:0];
  endfunction

  sbtl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (budget_r),
    .divisor  (worker_count_r),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // Handshakes
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  // Register readback
  always_comb begin
    unique case (paddr[2])
      REG_RATE_LIMIT:   prdata = rate_limit_r;
      REG_WORKER_COUNT: prdata = {25'd0, worker_count_r};
      default:          prdata = '0;
    endcase
  end

  // Sequencer and bucket update
  always_comb begin
    state_nxt     = state_r;
    budget_nxt    = budget_r;
    bytes_nxt     = bytes_r;
    rate_nxt      = rate_r;
    out_valid_nxt = out_valid_r && !out_ready;
    grant_nxt     = grant_r;
    wait_nxt      = wait_r;
    lrate_nxt     = lrate_r;
    div_ctl.start = 1'b0;
    want          = in_remaining_bytes;
    want_ok       = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          grant_nxt = '0;
          wait_nxt  = 1'b0;
          lrate_nxt = rate_r;
          unique case (cmd_e_t'(in_command))
            CMD_TICK: begin
              rate_nxt   = bytes_r;
              bytes_nxt  = '0;
              budget_nxt = rate_limit_r;
              lrate_nxt  = bytes_r;
            end
            CMD_GRANT: begin
              // Share the leftover budget when it falls short
              if (rate_limit_r != 32'd0 && budget_r < in_remaining_bytes) begin
                want_ok       = 1'b0;
                div_ctl.start = 1'b1;
                state_nxt     = S_DIV;
              end else if (rate_limit_r != 32'd0) begin
                budget_nxt = budget_r - in_remaining_bytes;
              end
              if (want_ok) begin
                wait_nxt  = (want == 32'd0);
                grant_nxt = cap_grant(want);
              end
            end
            CMD_REPORT: bytes_nxt = bytes_r + 32'(in_received_bytes);
            default: ;
          endcase
          out_valid_nxt = want_ok;
        end
      end
      S_DIV: begin
        // Take the share and debit it uncapped
        if (div_sts.done) begin
          budget_nxt    = budget_r - quotient;
          wait_nxt      = (quotient == 32'd0);
          grant_nxt     = cap_grant(quotient);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A limit write reloads the bucket
    if (cfg_wr && paddr[2] == REG_RATE_LIMIT) begin
      budget_nxt = pwdata;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      rate_limit_r   <= '0;
      worker_count_r <= WORKER_COUNT_RST;
      budget_r       <= '0;
      bytes_r        <= '0;
      rate_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      budget_r    <= budget_nxt;
      bytes_r     <= bytes_nxt;
      rate_r      <= rate_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_RATE_LIMIT:   rate_limit_r   <= pwdata;
          REG_WORKER_COUNT: worker_count_r <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    grant_r <= grant_nxt;
    wait_r  <= wait_nxt;
    lrate_r <= lrate_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_grant_bytes = grant_r;
  assign out_must_wait   = wait_r;
  assign out_last_rate   = lrate_r;

  // Checks
  `SBTL_ASSERT_IMPL(a_busy_blocks_input, div_sts.busy, !in_ready)
  `SBTL_ASSERT_NEXT(a_share_starts_div,
    in_acc && in_command == CMD_GRANT && rate_limit_r != 32'd0 &&
    budget_r < in_remaining_bytes, div_sts.busy)
  `SBTL_ASSERT_IMPL(a_done_slot_free, div_sts.done, !out_valid_r)
  `SBTL_ASSERT_IMPL(a_budget_in_limit, 1'b1, budget_r <= rate_limit_r)

endmodule
`default_nettype wire
